### hw/rtl/window_rate_tracker_core_assert.svh
// assertion macros shared by the rate tracker
`ifndef WINDOW_RATE_TRACKER_CORE_ASSERT_SVH
`define WINDOW_RATE_TRACKER_CORE_ASSERT_SVH
// property must hold on every clock edge out of reset
`define WRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked in the cycle after the antecedent
`define WRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/wrt_pkg.sv
// ----------------------------------------------------------------------------
// wrt_pkg
// shared types and constants of the window rate tracker
// ----------------------------------------------------------------------------
package wrt_pkg;
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_BAD_THR  = 2'd2;

    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] CFG_MIN_RATE    = 2'd1;
    localparam logic [1:0] CFG_GOOD_RATE   = 2'd2;
    localparam logic [1:0] CFG_EXC_RATE    = 2'd3;

    localparam logic [39:0] PICO_PER_SEC = 40'd1000000000000;

    typedef struct packed {
        logic [62:0] now_ns;
        logic [62:0] src_stamp_ns;
        logic        command;
    } wrt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        available;
        logic [31:0] rate_mhz;
        logic [31:0] raw_rate_mhz;
        logic [62:0] max_gap_ns;
        logic        gap_excluded;
        logic [1:0]  quality;
        logic [63:0] last_success_ns;
        logic [6:0]  win_count;
        logic [62:0] age_ns;
        logic        age_valid;
        logic        stamp_regressed;
    } wrt_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item, do the success update
        logic scan_start; // issue read of first entry
        logic scan_step;  // consume one read entry
        logic div_raw;    // start raw division
        logic div_cand;   // start candidate division
        logic take_raw;
        logic take_cand;
        logic finish;     // form output
    } wrt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic need_cand;
    } wrt_stat_t;
endpackage

### hw/rtl/wrt_stream_if.sv
// ----------------------------------------------------------------------------
// wrt_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface wrt_stream_if #(
    parameter int W = 8
) (
    input logic clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/window_rate_tracker_core.sv
// ----------------------------------------------------------------------------
// window_rate_tracker_core
// rate and freshness tracker over a window of recent success times
// ----------------------------------------------------------------------------
// in_ch carries {now_ns, source stamp, command}; out_ch carries one
// observation per item. config is written through cfg_we/cfg_index/cfg_data
// by the user, only while the block is idle; the block does not enforce it.
// an item is taken when the block is idle; it then scans the window (one
// entry per cycle through the ram read port) and runs one bit-serial
// division for the raw rate and, when the raw rate is under the minimum
// with at least four samples and a span above the largest gap, a second
// one. with fewer than three samples or a zero span the raw division is
// skipped. a new item is not taken before the previous one is processed.
// the result sits in an output register; a stalled receiver holds the
// result there while the next item is accepted and processed, and the
// block waits at the end of that item until the register frees up.
// reset empties the window, clears the last success and loads the
// default thresholds; ram contents are never read before written.
module window_rate_tracker_core
    import wrt_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    wrt_stream_if.sink     in_ch,
    wrt_stream_if.source   out_ch,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    `include "window_rate_tracker_core_assert.svh"

    logic [6:0]  win_size_reg;
    logic [31:0] min_reg, good_reg, exc_reg;
    wrt_cmd_t    cmd;
    wrt_stat_t   stat;
    wrt_out_t    out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg <= 7'd10;
            min_reg      <= 32'd1000;
            good_reg     <= 32'd5000;
            exc_reg      <= 32'd10000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE: win_size_reg <= cfg_data[6:0];
                CFG_MIN_RATE:    min_reg      <= cfg_data;
                CFG_GOOD_RATE:   good_reg     <= cfg_data;
                CFG_EXC_RATE:    exc_reg      <= cfg_data;
                default:         win_size_reg <= win_size_reg;
            endcase
        end
    end

    wrt_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wrt_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_item         (in_ch.data),
        .cfg_window_size (win_size_reg),
        .cfg_min         (min_reg),
        .cfg_good        (good_reg),
        .cfg_exc         (exc_reg),
        .out_item        (out_item)
    );

    assign out_ch.data = out_item;

    `WRT_ASSERT(a_load_only_on_accept, clk, rst_n,
        !cmd.load || (in_ch.valid && in_ch.ready), "load without accepted transaction")
    `WRT_ASSERT_NEXT(a_finish_sets_valid, clk, rst_n, cmd.finish, out_ch.valid,
        "result not presented after finish")
    `WRT_ASSERT(a_no_finish_over_pending, clk, rst_n,
        !(cmd.finish && out_ch.valid && !out_ch.ready), "result overwritten while stalled")
endmodule

### hw/rtl/wrt_ram.sv
// ----------------------------------------------------------------------------
// wrt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/wrt_divider.sv
// ----------------------------------------------------------------------------
// wrt_divider
// restoring divider, one quotient bit per cycle, quotient saturated to 32 bits
// ----------------------------------------------------------------------------
module wrt_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [62:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [62:0] dvs_reg, dvs_next;
    logic [63:0] q_reg, q_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_reg, dvd_reg[63]};
    assign diff    = shifted - {2'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            q_next    = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[62:0], 1'b0};
            if (!diff[64])
            begin
                rem_next = diff[63:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    // zero divisor never reaches here, callers guard it
    assign quotient = (q_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : q_reg[31:0];
endmodule

### hw/rtl/wrt_datapath.sv
// ----------------------------------------------------------------------------
// wrt_datapath
// window store, gap scan, rate division and result formatting
// ----------------------------------------------------------------------------
module wrt_datapath
    import wrt_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  wrt_cmd_t    cmd,
    output wrt_stat_t   stat,
    input  wrt_in_t     in_item,
    input  logic [6:0]  cfg_window_size,
    input  logic [31:0] cfg_min,
    input  logic [31:0] cfg_good,
    input  logic [31:0] cfg_exc,
    output wrt_out_t    out_item
);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          last_valid_reg;
    logic [62:0]   last_time_reg;
    logic [62:0]   last_stamp_reg;

    logic [62:0]   now_reg;
    logic          rejected_reg;
    logic          regressed_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic [62:0]   first_reg, prev_reg, max_gap_reg;
    logic [31:0]   raw_reg, rate_reg;
    logic          excl_reg;
    logic          first_seen_reg;

    logic          we;
    logic [62:0]   rdata;
    logic [AW-1:0] start_addr;
    logic [CW-1:0] size_cl;
    logic          thr_ok;
    logic [62:0]   span;
    logic [62:0]   gap;
    logic          div_start;
    logic [63:0]   div_dvd;
    logic [62:0]   div_dvs;
    logic          div_done;
    logic [31:0]   div_q;
    logic [CW-1:0] mult_n;
    logic          accept_succ;
    logic          raw_possible;

    assign thr_ok = (cfg_min != 32'd0) && (cfg_min <= cfg_good) && (cfg_good <= cfg_exc);

    // clamp the window size to 3..WINDOW_MAX
    always_comb
    begin
        if ({1'b0, cfg_window_size} < 8'd3)
        begin
            size_cl = CW'(3);
        end
        else if (32'(cfg_window_size) > 32'(WINDOW_MAX))
        begin
            size_cl = CW'(WINDOW_MAX);
        end
        else
        begin
            size_cl = CW'(cfg_window_size);
        end
    end

    assign accept_succ = in_item.command && !(last_valid_reg && in_item.now_ns <= last_time_reg);
    assign we = cmd.load && accept_succ;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (we)
        begin
            head_next = (32'(head_reg) == WINDOW_MAX - 1) ? '0 : head_reg + AW'(1);
            if (32'(count_reg) < WINDOW_MAX)
            begin
                count_next = count_reg + CW'(1);
            end
            if (count_next > size_cl)
            begin
                count_next = size_cl;
            end
        end
    end

    // oldest entry address: head minus count, modulo depth
    always_comb
    begin
        logic [CW:0] t;
        t = {1'b0, CW'(head_reg)} + (CW+1)'(WINDOW_MAX) - {1'b0, count_reg};
        if (32'(t) >= WINDOW_MAX)
        begin
            t = t - (CW+1)'(WINDOW_MAX);
        end
        start_addr = AW'(t);
    end

    // read address runs one entry ahead of the consumed data
    always_comb
    begin
        raddr_next = raddr_reg;
        if (cmd.scan_start)
        begin
            raddr_next = start_addr;
        end
        else if (cmd.scan_step)
        begin
            raddr_next = (32'(raddr_reg) == WINDOW_MAX - 1) ? '0 : raddr_reg + AW'(1);
        end
    end

    wrt_ram #(.WIDTH(63), .DEPTH(WINDOW_MAX)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (head_reg),
        .wdata (in_item.now_ns),
        .raddr (raddr_next),
        .rdata (rdata)
    );

    assign gap  = (rdata > prev_reg) ? rdata - prev_reg : 63'd0;
    assign span = (prev_reg > first_reg) ? prev_reg - first_reg : 63'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            last_valid_reg <= 1'b0;
            last_stamp_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (we)
            begin
                last_valid_reg <= 1'b1;
                if (in_item.src_stamp_ns != 63'd0)
                begin
                    last_stamp_reg <= in_item.src_stamp_ns;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg <= raddr_next;
        if (we)
        begin
            last_time_reg <= in_item.now_ns;
        end
        if (cmd.load)
        begin
            now_reg       <= in_item.now_ns;
            rejected_reg  <= in_item.command && !accept_succ;
            regressed_reg <= we && in_item.src_stamp_ns != 63'd0
                             && last_stamp_reg != 63'd0
                             && in_item.src_stamp_ns < last_stamp_reg;
        end
        if (cmd.scan_start)
        begin
            idx_reg        <= '0;
            max_gap_reg    <= '0;
            first_seen_reg <= 1'b0;
            raw_reg        <= '0;
            rate_reg       <= '0;
            excl_reg       <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            idx_reg   <= idx_reg + CW'(1);
            prev_reg  <= rdata;
            if (!first_seen_reg)
            begin
                first_reg      <= rdata;
                first_seen_reg <= 1'b1;
            end
            else if (gap > max_gap_reg)
            begin
                max_gap_reg <= gap;
            end
        end
        if (cmd.take_raw)
        begin
            raw_reg  <= div_q;
            rate_reg <= div_q;
        end
        if (cmd.take_cand && div_q >= cfg_min)
        begin
            rate_reg <= div_q;
            excl_reg <= 1'b1;
        end
    end

    // at least three times (span zero gives rate zero)
    assign raw_possible = (32'(count_reg) >= 3) && span != 63'd0;

    assign mult_n    = cmd.div_raw ? count_reg - CW'(1) : count_reg - CW'(2);
    assign div_start = (cmd.div_raw && raw_possible) || cmd.div_cand;
    assign div_dvd   = 64'(mult_n) * 64'(PICO_PER_SEC);
    assign div_dvs   = cmd.div_raw ? span : span - max_gap_reg;

    wrt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.scan_done = (idx_reg == count_reg);
    assign stat.div_done  = div_done || (cmd.div_raw && !raw_possible);
    assign stat.need_cand = (32'(count_reg) >= 4) && (raw_reg < cfg_min) && (span > max_gap_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_item.status <= rejected_reg ? STATUS_REJECTED
                               : (!thr_ok ? STATUS_BAD_THR : STATUS_OK);
            out_item.available    <= 32'(count_reg) >= 3;
            out_item.rate_mhz     <= rate_reg;
            out_item.raw_rate_mhz <= raw_reg;
            out_item.max_gap_ns   <= max_gap_reg;
            out_item.gap_excluded <= excl_reg;
            if (!thr_ok || rate_reg < cfg_min)
            begin
                out_item.quality <= 2'd0;
            end
            else if (rate_reg < cfg_good)
            begin
                out_item.quality <= 2'd1;
            end
            else if (rate_reg < cfg_exc)
            begin
                out_item.quality <= 2'd2;
            end
            else
            begin
                out_item.quality <= 2'd3;
            end
            out_item.last_success_ns <= last_valid_reg ? {1'b0, last_time_reg} : '1;
            out_item.win_count       <= 7'(count_reg);
            out_item.age_ns          <= (last_valid_reg && now_reg > last_time_reg)
                                        ? now_reg - last_time_reg : 63'd0;
            out_item.age_valid       <= last_valid_reg;
            out_item.stamp_regressed <= regressed_reg;
        end
    end
endmodule

### hw/rtl/wrt_control.sv
// ----------------------------------------------------------------------------
// wrt_control
// sequencer: load, scan, raw division, optional candidate division, output
// ----------------------------------------------------------------------------
module wrt_control
    import wrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  wrt_stat_t stat,
    output wrt_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_RAW   = 3'd3;
    localparam logic [2:0] S_CAND  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       wait_reg, wait_next;
    logic       ovalid_reg, ovalid_next;
    logic       started_reg, started_next;

    // a new item may enter while the previous result waits
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        ovalid_next  = ovalid_reg;
        started_next = started_reg;
        cmd          = '0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.scan_start = 1'b1;
                wait_next      = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                // first cycle only primes the registered read
                if (wait_reg)
                begin
                    wait_next = 1'b0;
                end
                else if (stat.scan_done)
                begin
                    state_next   = S_RAW;
                    started_next = 1'b0;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RAW:
            begin
                if (!started_reg)
                begin
                    cmd.div_raw  = 1'b1;
                    started_next = 1'b1;
                    if (stat.div_done)
                    begin
                        state_next = S_CAND;
                        started_next = 1'b0;
                    end
                end
                else if (stat.div_done)
                begin
                    cmd.take_raw = 1'b1;
                    state_next   = S_CAND;
                    started_next = 1'b0;
                end
            end
            S_CAND:
            begin
                if (!started_reg)
                begin
                    if (stat.need_cand)
                    begin
                        cmd.div_cand = 1'b1;
                        started_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (stat.div_done)
                begin
                    cmd.take_cand = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ovalid_next)
                begin
                    cmd.finish  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wait_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            ovalid_reg  <= ovalid_next;
            started_reg <= started_next;
        end
    end
endmodule
